// ===== rtl/battery_link_ring_animator_macros.svh =====
// Assertion macros for the battery link ring animator.
// Used by the top level; needs nothing else.
`ifndef BATTERY_LINK_RING_ANIMATOR_MACROS_SVH
`define BATTERY_LINK_RING_ANIMATOR_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define BLRA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define BLRA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BLRA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BLRA_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/blra_pkg.sv =====
// Shared types and constants of the battery link ring animator.
// No dependencies; imported by every module of the block.
`default_nettype none

package blra_pkg;

  localparam int CELLS = 6;
  localparam logic [4:0] CELLS_NEEDED = 5'(CELLS / 2);
  localparam logic [4:0] CELLS_SAT = 5'd31;
  localparam logic [15:0] V_LOW = 16'd2800;
  localparam logic [15:0] V_HIGH = 16'd4500;
  localparam logic [16:0] FULL_Q16 = 17'd65536;

  // Command codes.
  localparam logic [1:0] CMD_CELL = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_PIXEL = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_RING_SIZE = 3'd0;
  localparam logic [2:0] REG_CONNECT_STEP = 3'd1;
  localparam logic [2:0] REG_FILL_STEP = 3'd2;
  localparam logic [2:0] REG_SHRINK_STEP = 3'd3;
  localparam logic [2:0] REG_GREEN_LEVEL = 3'd4;

  typedef struct packed {
    logic [9:0]  ring_size;
    logic [16:0] connect_step;
    logic [16:0] fill_step;
    logic [16:0] shrink_step;
    logic [7:0]  green_level;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  command;
    logic        battery_select;
    logic [15:0] cell_voltage;
    logic        last_cell;
    logic [15:0] elapsed;
    logic [9:0]  pixel_index;
  } item_t;

  typedef struct packed {
    logic active;       // mode not inactive, current state
    logic active_next;  // mode not inactive once the held item is applied
    logic covers;       // held pixel item lies in this battery's arc
  } batt_status_t;

endpackage

`default_nettype wire

// ===== rtl/blra_cfg.sv =====
// Configuration register file of the battery link ring animator.
// Depends on blra_pkg.
`default_nettype none

module blra_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [16:0]   cfg_data,
  output blra_pkg::cfg_t cfg
);
  import blra_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ring_size    <= 10'd110;
      cfg.connect_step <= 17'd66;
      cfg.fill_step    <= 17'd131;
      cfg.shrink_step  <= 17'd66;
      cfg.green_level  <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RING_SIZE:    cfg.ring_size    <= cfg_data[9:0];
        REG_CONNECT_STEP: cfg.connect_step <= cfg_data;
        REG_FILL_STEP:    cfg.fill_step    <= cfg_data;
        REG_SHRINK_STEP:  cfg.shrink_step  <= cfg_data;
        REG_GREEN_LEVEL:  cfg.green_level  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/blra_batt.sv =====
// State and arc test of one battery: cell counting, link verdict, ramps.
// Depends on blra_pkg.
`default_nettype none

module blra_batt (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 batt_id,   // 0 centres at a quarter, 1 at three quarters
  input  logic                 advance,   // held item is applied this cycle
  input  blra_pkg::item_t      item,
  input  blra_pkg::cfg_t       cfg,
  output blra_pkg::batt_status_t status
);
  import blra_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_CONN   = 2'd1,
    MODE_FILL   = 2'd2,
    MODE_SHRINK = 2'd3
  } mode_t;

  mode_t       mode, mode_next;
  logic [16:0] progress, progress_next;
  logic        link_up, link_up_next;
  logic [4:0]  cells, cells_next;

  logic        in_range;
  logic [4:0]  cells_inc;
  logic        now_up;
  logic [16:0] step_sel;
  logic [32:0] delta;
  logic [33:0] sum;

  logic [11:0] centre, quarter_pos, gap, gap_wrap;
  logic [10:0] half_ring;
  logic [27:0] lhs;
  logic [26:0] rhs;

  // One multiplier serves the ramp of whichever mode is current.
  always_comb begin
    case (mode)
      MODE_CONN: step_sel = cfg.connect_step;
      MODE_FILL: step_sel = cfg.fill_step;
      default:   step_sel = cfg.shrink_step;
    endcase
  end

  assign delta = 33'(item.elapsed) * 33'(step_sel);
  assign sum   = 34'(progress) + 34'(delta);

  assign in_range  = (item.cell_voltage >= V_LOW) && (item.cell_voltage <= V_HIGH);
  assign cells_inc = (in_range && cells < CELLS_SAT) ? cells + 5'd1 : cells;
  assign now_up    = (cells_inc >= CELLS_NEEDED);

  always_comb begin
    mode_next     = mode;
    progress_next = progress;
    link_up_next  = link_up;
    cells_next    = cells;
    case (item.command)
      CMD_CELL: begin
        if (item.battery_select == batt_id) begin
          cells_next = cells_inc;
          if (item.last_cell) begin
            if (now_up && !link_up) begin
              mode_next     = MODE_CONN;
              progress_next = '0;
            end else if (!now_up && link_up) begin
              mode_next     = MODE_FILL;
              progress_next = '0;
            end
            link_up_next = now_up;
            cells_next   = '0;
          end
        end
      end
      CMD_TICK: begin
        unique case (mode)
          MODE_CONN, MODE_FILL: begin
            if (sum >= 34'(FULL_Q16)) begin
              progress_next = FULL_Q16;
              mode_next     = (mode == MODE_CONN) ? MODE_IDLE : MODE_SHRINK;
            end else begin
              progress_next = sum[16:0];
            end
          end
          MODE_SHRINK: begin
            if (delta >= 33'(progress)) begin
              progress_next = '0;
              mode_next     = MODE_IDLE;
            end else begin
              progress_next = progress - delta[16:0];
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_IDLE;
      progress <= '0;
      link_up  <= 1'b0;
      cells    <= '0;
    end else if (advance) begin
      mode     <= mode_next;
      progress <= progress_next;
      link_up  <= link_up_next;
      cells    <= cells_next;
    end
  end

  // Arc test in quarter-LED units; the distance wraps round the ring.
  assign centre      = batt_id ? 12'(3 * int'(cfg.ring_size)) : 12'(cfg.ring_size);
  assign quarter_pos = {item.pixel_index, 2'b00};
  assign gap         = (quarter_pos >= centre) ? quarter_pos - centre : centre - quarter_pos;
  assign half_ring   = {cfg.ring_size, 1'b0};
  assign gap_wrap    = (gap > 12'(half_ring)) ? {cfg.ring_size, 2'b00} - gap : gap;
  assign lhs         = {gap_wrap, 16'd0};
  assign rhs         = 27'(cfg.ring_size) * 27'(progress);

  assign status.active      = (mode != MODE_IDLE);
  assign status.active_next = (mode_next != MODE_IDLE);
  assign status.covers      = (mode != MODE_IDLE) && (lhs <= 28'(rhs));

endmodule

`default_nettype wire

// ===== rtl/battery_link_ring_animator.sv =====
// Top level of the battery link ring animator: input register, two battery
// units, result register. Depends on blra_pkg, blra_cfg, blra_batt and the macro header.
//
//  Channel   Handshake                 Payload
//  item      item_valid / item_stall   command, battery_select, cell_voltage,
//                                      last_cell, elapsed, pixel_index
//  result    result_valid / result_stall  pixel_lit, pixel_green, effect_active
//  cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item per cycle while result_stall is low; each result is registered.
// Battery state is updated as an item passes from the input register to the
// result register, so each item sees the state left by the one before it.
// A stalled result holds the input register, and item_stall rises only while
// that register is full. Reset is synchronous; configuration is always ready.
`default_nettype none
`include "battery_link_ring_animator_macros.svh"

module battery_link_ring_animator (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  command,
  input  logic        battery_select,
  input  logic [15:0] cell_voltage,
  input  logic        last_cell,
  input  logic [15:0] elapsed,
  input  logic [9:0]  pixel_index,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        pixel_lit,
  output logic [7:0]  pixel_green,
  output logic        effect_active,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  import blra_pkg::*;

  cfg_t         cfg;
  item_t        held;
  logic         held_valid;
  logic         advance;
  logic         lit;
  batt_status_t st0, st1;

  assign advance    = held_valid && !(result_valid && result_stall);
  assign item_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held.command        <= command;
      held.battery_select <= battery_select;
      held.cell_voltage   <= cell_voltage;
      held.last_cell      <= last_cell;
      held.elapsed        <= elapsed;
      held.pixel_index    <= pixel_index;
    end
  end

  blra_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  blra_batt u_batt0 (
    .clk     (clk),
    .rst     (rst),
    .batt_id (1'b0),
    .advance (advance),
    .item    (held),
    .cfg     (cfg),
    .status  (st0)
  );

  blra_batt u_batt1 (
    .clk     (clk),
    .rst     (rst),
    .batt_id (1'b1),
    .advance (advance),
    .item    (held),
    .cfg     (cfg),
    .status  (st1)
  );

  assign lit = (held.command == CMD_PIXEL) && (cfg.ring_size != 10'd0) &&
               (held.pixel_index < cfg.ring_size) && (st0.covers || st1.covers);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!(result_valid && result_stall)) begin
      result_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pixel_lit     <= lit;
      pixel_green   <= lit ? cfg.green_level : 8'd0;
      effect_active <= st0.active_next || st1.active_next;
    end
  end

  `BLRA_ASSERT_IMP(a_dark_is_zero, clk, rst, result_valid && !pixel_lit, pixel_green == 8'd0)
  `BLRA_ASSERT_IMP(a_stall_when_full, clk, rst, item_stall, held_valid)
  `BLRA_ASSERT_NXT(a_held_moves_on, clk, rst, advance, result_valid)
  `BLRA_ASSERT_IMP(a_active_ok, clk, rst, result_valid, effect_active == (st0.active || st1.active))

endmodule

`default_nettype wire

// ===== test/tb_battery_link_ring_animator.sv =====
// Self-checking testbench for the battery link ring animator: directed ramps, then random
// cell, tick and pixel beats under several register settings, checked against a local model.
// Depends on blra_pkg and the battery_link_ring_animator RTL.
`default_nettype none

module tb_battery_link_ring_animator;
  timeunit 1ns;
  timeprecision 1ps;
  import blra_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int BREAK_PCT = 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 113;
  localparam logic [16:0] STEP_MAX = 17'h1FFFF;

  typedef enum logic [1:0] {RAMP_OFF, RAMP_CONNECT, RAMP_FILL, RAMP_SHRINK} ramp_t;

  typedef struct packed {
    logic       lit;
    logic [7:0] green;
    logic       active;
  } ring_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [1:0]  command = '0;
  logic        battery_select = 1'b0;
  logic [15:0] cell_voltage = '0;
  logic        last_cell = 1'b0;
  logic [15:0] elapsed = '0;
  logic [9:0]  pixel_index = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        pixel_lit;
  logic [7:0]  pixel_green;
  logic        effect_active;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  // Model copy of the registers and of each battery's animation state.
  logic [9:0]  set_ring_size;
  logic [16:0] set_connect;
  logic [16:0] set_fill;
  logic [16:0] set_shrink;
  logic [7:0]  set_green;
  ramp_t       ramp_mode [2];
  logic [16:0] ramp_pos [2];
  bit          link_up [2];
  logic [4:0]  cell_count [2];

  ring_result_t pending_results [$];
  ring_result_t want;
  bit calm = 1'b0;
  int error_count = 0;
  int beats_sent = 0;
  int results_checked = 0;
  int lit_seen = 0;
  int settings_used = 1;
  int quiet_cycles = 0;

  battery_link_ring_animator dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .command(command), .battery_select(battery_select), .cell_voltage(cell_voltage),
    .last_cell(last_cell), .elapsed(elapsed), .pixel_index(pixel_index),
    .result_valid(result_valid), .result_stall(result_stall),
    .pixel_lit(pixel_lit), .pixel_green(pixel_green), .effect_active(effect_active),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void reset_ring_model();
    set_ring_size = 10'd110;
    set_connect = 17'd66;
    set_fill = 17'd131;
    set_shrink = 17'd66;
    set_green = 8'd255;
    for (int b = 0; b < 2; b++) begin
      ramp_mode[b] = RAMP_OFF;
      ramp_pos[b] = '0;
      link_up[b] = 1'b0;
      cell_count[b] = '0;
    end
  endfunction

  function automatic void step_ramp(int b, longint unsigned ms);
    longint unsigned p;
    longint unsigned dec;
    p = ramp_pos[b];
    case (ramp_mode[b])
      RAMP_CONNECT: begin
        p = p + ms * set_connect;
        if (p >= FULL_Q16) begin
          p = FULL_Q16;
          ramp_mode[b] = RAMP_OFF;
        end
      end
      RAMP_FILL: begin
        p = p + ms * set_fill;
        if (p >= FULL_Q16) begin
          p = FULL_Q16;
          ramp_mode[b] = RAMP_SHRINK;
        end
      end
      RAMP_SHRINK: begin
        dec = ms * set_shrink;
        if (dec >= p) begin
          p = 0;
          ramp_mode[b] = RAMP_OFF;
        end else begin
          p = p - dec;
        end
      end
      default: ;
    endcase
    ramp_pos[b] = p[16:0];
  endfunction

  // Distances are kept in quarter-LED units so that the arc test stays exact.
  function automatic bit in_arc(int b, logic [9:0] j);
    longint unsigned n;
    longint unsigned centre;
    longint unsigned q;
    longint unsigned d;
    if (ramp_mode[b] == RAMP_OFF) return 1'b0;
    n = set_ring_size;
    centre = (b == 0) ? n : 3 * n;
    q = 4 * longint'(j);
    d = (q >= centre) ? q - centre : centre - q;
    if (d > 2 * n) d = 4 * n - d;
    return d * FULL_Q16 <= n * ramp_pos[b];
  endfunction

  function automatic ring_result_t predict_ring(item_t it);
    ring_result_t r;
    int b;
    bit now_up;
    r.lit = 1'b0;
    case (it.command)
      CMD_CELL: begin
        b = it.battery_select;
        if (it.cell_voltage >= V_LOW && it.cell_voltage <= V_HIGH && cell_count[b] < CELLS_SAT)
          cell_count[b] = cell_count[b] + 5'd1;
        if (it.last_cell) begin
          now_up = cell_count[b] >= CELLS_NEEDED;
          if (now_up && !link_up[b]) begin
            ramp_mode[b] = RAMP_CONNECT;
            ramp_pos[b] = '0;
          end else if (!now_up && link_up[b]) begin
            ramp_mode[b] = RAMP_FILL;
            ramp_pos[b] = '0;
          end
          link_up[b] = now_up;
          cell_count[b] = '0;
        end
      end
      CMD_TICK: begin
        step_ramp(0, it.elapsed);
        step_ramp(1, it.elapsed);
      end
      CMD_PIXEL: begin
        if (set_ring_size != 0 && it.pixel_index < set_ring_size &&
            (in_arc(0, it.pixel_index) || in_arc(1, it.pixel_index)))
          r.lit = 1'b1;
      end
      default: ;
    endcase
    r.green = r.lit ? set_green : 8'd0;
    r.active = (ramp_mode[0] != RAMP_OFF) || (ramp_mode[1] != RAMP_OFF);
    return r;
  endfunction

  function automatic bit take_break();
    return !calm && $urandom_range(99) < BREAK_PCT;
  endfunction

  // Items accepted on this edge are predicted; results accepted are checked in order.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          $error("result beat arrived with no expectation waiting");
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (pixel_lit !== want.lit) begin
            $error("pixel_lit: expected %0d, got %0d", want.lit, pixel_lit);
            error_count++;
          end
          if (pixel_green !== want.green) begin
            $error("pixel_green: expected %0d, got %0d", want.green, pixel_green);
            error_count++;
          end
          if (effect_active !== want.active) begin
            $error("effect_active: expected %0d, got %0d", want.active, effect_active);
            error_count++;
          end
          if (want.lit) lit_seen++;
        end
      end
      if (item_valid && !item_stall)
        pending_results.push_back(predict_ring('{command, battery_select, cell_voltage,
                                                 last_cell, elapsed, pixel_index}));
      if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  always @(negedge clk) result_stall <= take_break();

  task automatic send(input item_t it);
    @(negedge clk);
    while (take_break()) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    command <= it.command;
    battery_select <= it.battery_select;
    cell_voltage <= it.cell_voltage;
    last_cell <= it.last_cell;
    elapsed <= it.elapsed;
    pixel_index <= it.pixel_index;
    do @(posedge clk); while (item_stall);
    beats_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [16:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_RING_SIZE: set_ring_size = value[9:0];
      REG_CONNECT_STEP: set_connect = value;
      REG_FILL_STEP: set_fill = value;
      REG_SHRINK_STEP: set_shrink = value;
      REG_GREEN_LEVEL: set_green = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Unused fields carry random bits so that every input bit toggles.
  function automatic item_t noise_item(logic [1:0] cmd);
    item_t it;
    it.command = cmd;
    it.battery_select = 1'($urandom_range(1));
    it.cell_voltage = 16'($urandom_range(65535));
    it.last_cell = 1'($urandom_range(1));
    it.elapsed = 16'($urandom_range(65535));
    it.pixel_index = 10'($urandom_range(1023));
    return it;
  endfunction

  task automatic send_cell(input bit b, input logic [15:0] v, input bit last);
    item_t it;
    it = noise_item(CMD_CELL);
    it.battery_select = b;
    it.cell_voltage = v;
    it.last_cell = last;
    send(it);
  endtask

  task automatic send_tick(input logic [15:0] ms);
    item_t it;
    it = noise_item(CMD_TICK);
    it.elapsed = ms;
    send(it);
  endtask

  task automatic send_pixel(input logic [9:0] j);
    item_t it;
    it = noise_item(CMD_PIXEL);
    it.pixel_index = j;
    send(it);
  endtask

  task automatic test_idle_after_reset();
    item_t it;
    send_pixel(10'd0);
    send_pixel(10'd1023);
    it = '1;
    it.command = CMD_SPARE;
    send(it);
    send_tick(16'd0);
  endtask

  // Two in-band cells fall short of the threshold; three good ones connect battery 0.
  task automatic test_connect_ramp();
    send_cell(1'b0, V_LOW - 16'd1, 1'b0);
    send_cell(1'b0, V_LOW, 1'b0);
    send_cell(1'b0, V_HIGH, 1'b0);
    send_cell(1'b0, V_HIGH + 16'd1, 1'b1);
    send_cell(1'b0, 16'd3000, 1'b0);
    send_cell(1'b0, 16'd3000, 1'b0);
    send_cell(1'b0, 16'd3000, 1'b1);
    send_pixel(10'd27);
    send_tick(16'd500);
    send_pixel(10'd27);
    send_pixel(10'd54);
    send_tick(16'hFFFF);
    send_pixel(10'd27);
  endtask

  task automatic test_disconnect_ramp();
    send_cell(1'b0, 16'hFFFF, 1'b1);
    send_tick(16'd0);
    send_tick(16'hFFFF);
    send_pixel(10'd0);
    send_cell(1'b1, V_HIGH, 1'b0);
    send_cell(1'b1, V_HIGH, 1'b0);
    send_cell(1'b1, V_LOW, 1'b1);
    send_pixel(10'd82);
    send_tick(16'hFFFF);
    send_pixel(10'd0);
  endtask

  function automatic logic [15:0] pick_voltage(bit in_band);
    case ($urandom_range(9))
      0: return in_band ? V_LOW : V_LOW - 16'd1;
      1: return in_band ? V_HIGH : V_HIGH + 16'd1;
      default: begin
        if (in_band) return 16'($urandom_range(V_HIGH, V_LOW));
        if ($urandom_range(1)) return 16'($urandom_range(V_LOW - 1));
        return 16'($urandom_range(65535, V_HIGH + 1));
      end
    endcase
  endfunction

  function automatic logic [16:0] pick_step();
    case ($urandom_range(9))
      0: return 17'd0;
      1: return FULL_Q16;
      2: return STEP_MAX;
      default: return 17'($urandom_range(4000, 1));
    endcase
  endfunction

  function automatic logic [16:0] pick_ring_size();
    case ($urandom_range(7))
      0: return 17'd0;
      1: return 17'd1;
      2: return 17'd1023;
      3: return 17'($urandom_range(8, 2));
      default: return 17'($urandom_range(300, 9));
    endcase
  endfunction

  task automatic write_settings(input int phase);
    logic [16:0] leds;
    logic [16:0] s_conn;
    logic [16:0] s_fill;
    logic [16:0] s_shr;
    logic [16:0] grn;
    leds = pick_ring_size();
    s_conn = pick_step();
    s_fill = pick_step();
    s_shr = pick_step();
    grn = ($urandom_range(3) == 0) ? 17'd0 : 17'($urandom_range(255));
    case (phase)
      1: begin
        leds = 17'd1023;
        s_conn = FULL_Q16;
        s_fill = FULL_Q16;
        s_shr = FULL_Q16;
        grn = 17'd255;
      end
      2: begin
        leds = 17'd0;
        s_conn = 17'd0;
        s_fill = 17'd0;
        s_shr = 17'd0;
        grn = 17'd0;
      end
      3: begin
        leds = 17'd1;
        s_conn = STEP_MAX;
        s_fill = STEP_MAX;
        s_shr = STEP_MAX;
      end
      default: ;
    endcase
    drain();
    set_reg(REG_RING_SIZE, leds);
    set_reg(REG_CONNECT_STEP, s_conn);
    set_reg(REG_FILL_STEP, s_fill);
    set_reg(REG_SHRINK_STEP, s_shr);
    set_reg(REG_GREEN_LEVEL, grn);
    settings_used++;
  endtask

  // Mostly whole cell sets, ticks and pixel queries, with a little noise mixed in.
  task automatic run_random_beats(input int count);
    int sent;
    int len;
    int pick;
    bit b;
    bit good;
    logic [9:0] j;
    item_t it;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        b = 1'($urandom_range(1));
        good = 1'($urandom_range(1));
        len = ($urandom_range(6) == 0) ? $urandom_range(40, 1) : CELLS;
        for (int k = 0; k < len; k++)
          send_cell(b, pick_voltage(good ? ($urandom_range(5) != 0) : ($urandom_range(5) == 0)),
                    k == len - 1);
        sent += len;
      end else if (pick < 55) begin
        send_tick(($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                           : 16'($urandom_range(40)));
        sent++;
      end else if (pick < 97) begin
        if (set_ring_size == 0 || $urandom_range(6) == 0)
          j = ($urandom_range(1) && set_ring_size != 0) ? set_ring_size
                                                        : 10'($urandom_range(1023));
        else
          j = 10'($urandom_range(set_ring_size - 1));
        send_pixel(j);
        sent++;
      end else begin
        it = noise_item($urandom_range(1) ? CMD_SPARE : CMD_CELL);
        send(it);
        sent++;
      end
    end
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) write_settings(phase);
      calm = (phase == 4);
      if (phase == 6) begin
        run_random_beats(PHASE_ITEMS / 2);
        // Hold the sender back until every outstanding result has come out.
        drain();
        run_random_beats(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        run_random_beats(PHASE_ITEMS);
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    reset_ring_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_idle_after_reset();
    test_connect_ramp();
    test_disconnect_ramp();
    test_random_settings();
    drain();
    repeat (4) @(posedge clk);
    $display("covered %0d item beats under %0d register settings", beats_sent, settings_used);
    $display("checked %0d results, %0d of them lit pixels", results_checked, lit_seen);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
